// ===== src/rfpf_pkg.sv =====
// rfpf_pkg: shared types, field widths and defaults for the page framebuffer
// used by every file of the block except rfpf_ram; depends on nothing

package rfpf_pkg;

    localparam int SCREEN_ROWS_DEF    = 64;
    localparam int SCREEN_COLUMNS_DEF = 128;

    localparam int OP_W            = 2;
    localparam int ROW_START_W     = 6;
    localparam int COL_START_W     = 7;
    localparam int RECT_HEIGHT_W   = 7;
    localparam int RECT_WIDTH_W    = 8;
    localparam int READ_PAGE_W     = 3;
    localparam int READ_COLUMN_W   = 7;
    localparam int PAGE_BYTE_W     = 8;

    // wide enough for start plus size before clipping, and for the screen size
    localparam int ROW_SUM_W = 8;
    localparam int COL_SUM_W = 9;

    typedef enum logic [OP_W-1:0] {
        OP_FILL = 2'd0,
        OP_XFER = 2'd1,
        OP_READ = 2'd2,
        OP_NOP  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FILL,
        ST_XFER,
        ST_READ,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic load_fill;
        logic load_xfer;
        logic load_read;
        logic clear;
        logic fill;
        logic xfer;
        logic result;
    } t_dp_cmd;

    typedef struct packed {
        logic last;
        logic fill_empty;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== src/rfpf_in_if.sv =====
// rfpf_in_if: input channel, valid/ready plus the item fields
// depends on rfpf_pkg

interface rfpf_in_if import rfpf_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          op;
    logic [ROW_START_W-1:0]   row_start;
    logic [COL_START_W-1:0]   col_start;
    logic [RECT_HEIGHT_W-1:0] rect_height;
    logic [RECT_WIDTH_W-1:0]  rect_width;
    logic [READ_PAGE_W-1:0]   read_page;
    logic [READ_COLUMN_W-1:0] read_column;

    modport source (
        output valid, op, row_start, col_start, rect_height, rect_width,
               read_page, read_column,
        input  ready
    );
    modport sink (
        input  valid, op, row_start, col_start, rect_height, rect_width,
               read_page, read_column,
        output ready
    );
endinterface

// ===== src/rfpf_out_if.sv =====
// rfpf_out_if: result channel, valid/ready plus the page byte
// depends on rfpf_pkg

interface rfpf_out_if import rfpf_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [PAGE_BYTE_W-1:0] page_byte;

    modport source (output valid, page_byte, input ready);
    modport sink   (input valid, page_byte, output ready);
endinterface

// ===== src/rfpf_ram.sv =====
// rfpf_ram: generic simple dual port ram, one write and one registered read
// standalone, no package needed

module rfpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/rfpf_ctrl.sv =====
// rfpf_ctrl: sequencer for clearing pass, fill, transfer and read
// depends on rfpf_pkg; drives rfpf_dp through t_dp_cmd

module rfpf_ctrl import rfpf_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic [OP_W-1:0] i_in_op,
    output logic            o_in_ready,
    input  t_dp_sts         i_sts,
    output t_dp_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = (r_state == ST_IDLE) && i_in_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_sts.last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (t_op'(i_in_op))
                        OP_FILL: n_state = i_sts.fill_empty ? ST_IDLE : ST_FILL;
                        OP_XFER: n_state = ST_XFER;
                        OP_READ: n_state = ST_READ;
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_FILL, ST_XFER: begin
                if (i_sts.last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_READ: n_state = ST_RESULT;
            ST_RESULT: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        o_in_ready       = (r_state == ST_IDLE);
        o_cmd            = '0;
        o_cmd.load_fill  = accept && (t_op'(i_in_op) == OP_FILL);
        o_cmd.load_xfer  = accept && (t_op'(i_in_op) == OP_XFER);
        o_cmd.load_read  = accept && (t_op'(i_in_op) == OP_READ);
        o_cmd.clear      = (r_state == ST_CLEAR);
        o_cmd.fill       = (r_state == ST_FILL);
        o_cmd.xfer       = (r_state == ST_XFER);
        o_cmd.result     = (r_state == ST_RESULT) && i_sts.out_free;
    end

    a_read_then_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_READ |=> r_state == ST_RESULT)
        else $error("read did not move to result");

    a_clear_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR && !i_sts.last) |=> r_state == ST_CLEAR)
        else $error("clearing pass ended early");

    a_walk_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_FILL || r_state == ST_XFER) && i_sts.last)
        |=> r_state == ST_IDLE)
        else $error("walk did not stop at last word");

endmodule

// ===== src/rfpf_dp.sv =====
// rfpf_dp: address walker, read-modify-write stage, both planes and result register
// depends on rfpf_pkg and rfpf_ram

module rfpf_dp import rfpf_pkg::*; #(
    parameter int SCREEN_ROWS    = SCREEN_ROWS_DEF,
    parameter int SCREEN_COLUMNS = SCREEN_COLUMNS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    output t_dp_sts                  o_sts,
    input  logic [ROW_START_W-1:0]   i_row_start,
    input  logic [COL_START_W-1:0]   i_col_start,
    input  logic [RECT_HEIGHT_W-1:0] i_rect_height,
    input  logic [RECT_WIDTH_W-1:0]  i_rect_width,
    input  logic [READ_PAGE_W-1:0]   i_read_page,
    input  logic [READ_COLUMN_W-1:0] i_read_column,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [PAGE_BYTE_W-1:0]   o_out_byte
);

    localparam int PAGE_COUNT = (SCREEN_ROWS + 7) / 8;
    localparam int PG_W       = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int CW         = $clog2(SCREEN_COLUMNS);
    localparam int AW         = PG_W + CW;
    localparam int DEPTH      = 1 << AW;

    // item decode
    logic [ROW_SUM_W-1:0]   row_sum;
    logic [ROW_SUM_W-1:0]   row_end;
    logic [ROW_SUM_W-1:0]   row_last;
    logic [COL_SUM_W-1:0]   col_sum;
    logic [COL_SUM_W-1:0]   col_end;
    logic                   rd_oob;

    // walker
    logic [PG_W-1:0]        r_page;
    logic [CW-1:0]          r_col;
    logic [CW-1:0]          r_col_first;
    logic [CW-1:0]          r_col_last;
    logic [PG_W-1:0]        r_page_last;
    logic [ROW_START_W-1:0] r_row_start;
    logic [ROW_SUM_W-1:0]   r_row_end;
    logic                   r_rd_oob;
    logic                   step;
    logic                   col_wrap;
    logic [AW-1:0]          cur_addr;
    logic [7:0]             page_mask;

    // write stage
    logic                   r_wr_pix;
    logic                   r_wr_pg;
    logic [AW-1:0]          r_wr_addr;
    logic [7:0]             r_wr_mask;

    // memories
    logic                   pix_we;
    logic [AW-1:0]          pix_waddr;
    logic [7:0]             pix_wdata;
    logic [7:0]             pix_q;
    logic                   pg_we;
    logic [AW-1:0]          pg_waddr;
    logic [7:0]             pg_wdata;
    logic [7:0]             pg_q;

    logic                   r_out_valid;
    logic [PAGE_BYTE_W-1:0] r_out_byte;

    always_comb begin
        row_sum  = ROW_SUM_W'(i_row_start) + ROW_SUM_W'(i_rect_height);
        row_end  = (row_sum > ROW_SUM_W'(SCREEN_ROWS)) ? ROW_SUM_W'(SCREEN_ROWS) : row_sum;
        row_last = row_end - ROW_SUM_W'(1);
        col_sum  = COL_SUM_W'(i_col_start) + COL_SUM_W'(i_rect_width);
        col_end  = (col_sum > COL_SUM_W'(SCREEN_COLUMNS)) ?
                   COL_SUM_W'(SCREEN_COLUMNS) : col_sum;
        rd_oob   = (8'(i_read_page) >= 8'(PAGE_COUNT)) ||
                   (9'(i_read_column) >= 9'(SCREEN_COLUMNS));
    end

    assign step     = i_cmd.clear || i_cmd.fill || i_cmd.xfer;
    assign col_wrap = (r_col == r_col_last);
    assign cur_addr = {r_page, r_col};

    // rows of the current page that fall inside the rectangle
    always_comb begin
        logic [ROW_SUM_W-1:0] row;
        for (int k = 0; k < 8; k++) begin
            row          = ROW_SUM_W'({r_page, 3'(k)});
            page_mask[k] = (row >= ROW_SUM_W'(r_row_start)) && (row < r_row_end);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // set up the clearing pass over every page and column
            r_page      <= '0;
            r_col       <= '0;
            r_col_first <= '0;
            r_col_last  <= CW'(SCREEN_COLUMNS - 1);
            r_page_last <= PG_W'(PAGE_COUNT - 1);
        end else if (i_cmd.load_fill) begin
            r_page      <= PG_W'(i_row_start[ROW_START_W-1:3]);
            r_col       <= CW'(i_col_start);
            r_col_first <= CW'(i_col_start);
            r_col_last  <= CW'(col_end - COL_SUM_W'(1));
            r_page_last <= PG_W'(row_last[ROW_SUM_W-1:3]);
        end else if (i_cmd.load_xfer) begin
            r_page      <= '0;
            r_col       <= '0;
            r_col_first <= '0;
            r_col_last  <= CW'(SCREEN_COLUMNS - 1);
            r_page_last <= PG_W'(PAGE_COUNT - 1);
        end else if (i_cmd.load_read) begin
            r_page      <= PG_W'(i_read_page);
            r_col       <= CW'(i_read_column);
        end else if (step) begin
            if (col_wrap) begin
                r_col  <= r_col_first;
                r_page <= r_page + PG_W'(1);
            end else begin
                r_col  <= r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_fill) begin
            r_row_start <= i_row_start;
            r_row_end   <= row_end;
        end
        if (i_cmd.load_read) begin
            r_rd_oob <= rd_oob;
        end
        r_wr_addr <= cur_addr;
        r_wr_mask <= page_mask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_pix <= 1'b0;
            r_wr_pg  <= 1'b0;
        end else begin
            r_wr_pix <= i_cmd.fill;
            r_wr_pg  <= i_cmd.xfer;
        end
    end

    // clearing writes go straight in, fill and transfer write in the cycle after the read
    always_comb begin
        pix_we    = i_cmd.clear || r_wr_pix;
        pix_waddr = i_cmd.clear ? cur_addr : r_wr_addr;
        pix_wdata = i_cmd.clear ? 8'h00 : (pix_q | r_wr_mask);
        pg_we     = i_cmd.clear || r_wr_pg;
        pg_waddr  = i_cmd.clear ? cur_addr : r_wr_addr;
        pg_wdata  = i_cmd.clear ? 8'h00 : (pg_q | pix_q);
    end

    rfpf_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_pix_ram (
        .i_clk   (i_clk),
        .i_we    (pix_we),
        .i_waddr (pix_waddr),
        .i_wdata (pix_wdata),
        .i_raddr (cur_addr),
        .o_rdata (pix_q)
    );

    rfpf_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_pg_ram (
        .i_clk   (i_clk),
        .i_we    (pg_we),
        .i_waddr (pg_waddr),
        .i_wdata (pg_wdata),
        .i_raddr (cur_addr),
        .o_rdata (pg_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.result) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.result) begin
            r_out_byte <= r_rd_oob ? '0 : PAGE_BYTE_W'(pg_q);
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_byte       = r_out_byte;
    assign o_sts.last       = col_wrap && (r_page == r_page_last);
    assign o_sts.fill_empty = (ROW_SUM_W'(i_row_start) >= row_end) ||
                              (COL_SUM_W'(i_col_start) >= col_end);
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    a_one_rmw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_wr_pix && r_wr_pg))
        else $error("fill and transfer writes overlap");

    a_no_clear_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_pix || r_wr_pg) |-> !i_cmd.clear)
        else $error("pipelined write during clearing pass");

    a_oob_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.result && r_rd_oob) |=> (r_out_valid && r_out_byte == '0))
        else $error("off-screen read gave nonzero byte");

endmodule

// ===== src/rect_fill_page_framebuffer_unit.sv =====
// rect_fill_page_framebuffer_unit: top level of the two-plane page framebuffer
// depends on rfpf_pkg, rfpf_in_if, rfpf_out_if, rfpf_ctrl, rfpf_dp, rfpf_ram
//
//   channel  dir  payload                                     results
//   i_in     in   op, rectangle corner and size, read address  per item
//   o_out    out  page_byte                                   one per read item
//
// fill: walks each page byte touched (pages spanned x clipped width)
// transfer: walks all PAGE_COUNT x SCREEN_COLUMNS page bytes, 1024 at the defaults
// read: looks up one page byte, and waits while the result register is still held by the sink
// the walk is set by one word per cycle through each plane's memory port
// after reset a clearing pass over all PAGE_COUNT x SCREEN_COLUMNS page bytes (1024) runs
// with i_in.ready low; a waiting result does not block fill or transfer items

module rect_fill_page_framebuffer_unit import rfpf_pkg::*; #(
    parameter int SCREEN_ROWS    = SCREEN_ROWS_DEF,
    parameter int SCREEN_COLUMNS = SCREEN_COLUMNS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rfpf_in_if.sink    i_in,
    rfpf_out_if.source o_out
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    rfpf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_op    (i_in.op),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rfpf_dp #(
        .SCREEN_ROWS    (SCREEN_ROWS),
        .SCREEN_COLUMNS (SCREEN_COLUMNS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_row_start   (i_in.row_start),
        .i_col_start   (i_in.col_start),
        .i_rect_height (i_in.rect_height),
        .i_rect_width  (i_in.rect_width),
        .i_read_page   (i_in.read_page),
        .i_read_column (i_in.read_column),
        .o_out_valid   (o_out.valid),
        .i_out_ready   (o_out.ready),
        .o_out_byte    (o_out.page_byte)
    );

endmodule

// ===== sim/rect_fill_page_framebuffer_unit_tb.sv =====
`timescale 1ns / 1ps
// rect_fill_page_framebuffer_unit_tb: random and directed fill/transfer/read traffic against
// a shadow of both planes; depends on rfpf_pkg, rfpf_in_if, rfpf_out_if and the unit itself

module rect_fill_page_framebuffer_unit_tb;
    import rfpf_pkg::*;

    localparam int ROWS        = SCREEN_ROWS_DEF;
    localparam int COLS        = SCREEN_COLUMNS_DEF;
    localparam int PAGES       = (ROWS + 7) / 8;
    localparam int ITEM_TARGET = 580;
    localparam int MAX_IDLE    = 14;
    localparam int TAIL_CYCLES = 1100;
    localparam int CYCLE_LIMIT = 3_000_000;

    typedef struct {
        t_op                      op;
        logic [ROW_START_W-1:0]   row_start;
        logic [COL_START_W-1:0]   col_start;
        logic [RECT_HEIGHT_W-1:0] rect_height;
        logic [RECT_WIDTH_W-1:0]  rect_width;
        logic [READ_PAGE_W-1:0]   read_page;
        logic [READ_COLUMN_W-1:0] read_column;
    } t_fb_item;

    // shadow copy of both planes plus the page bytes still owed by the block
    class t_page_shadow;
        bit [7:0] pixels [PAGES][COLS];
        bit [7:0] pages  [PAGES][COLS];
        bit [PAGE_BYTE_W-1:0] owed_bytes [$];
        int n_fill, n_xfer, n_read, n_nop, n_checked, n_bad;

        function new();
            foreach (pixels[p, c]) begin
                pixels[p][c] = '0;
                pages[p][c]  = '0;
            end
        endfunction

        function int pending();
            return owed_bytes.size();
        endfunction

        function void note_item(t_fb_item it);
            int r_end, c_end;
            case (it.op)
                OP_FILL: begin
                    n_fill++;
                    r_end = int'(it.row_start) + int'(it.rect_height);
                    c_end = int'(it.col_start) + int'(it.rect_width);
                    if (r_end > ROWS) r_end = ROWS;
                    if (c_end > COLS) c_end = COLS;
                    for (int r = int'(it.row_start); r < r_end; r++)
                        for (int c = int'(it.col_start); c < c_end; c++)
                            pixels[r / 8][c] |= 8'(1 << (r % 8));
                end
                OP_XFER: begin
                    n_xfer++;
                    foreach (pages[p, c]) pages[p][c] |= pixels[p][c];
                end
                OP_READ: begin
                    n_read++;
                    if (int'(it.read_page) < PAGES && int'(it.read_column) < COLS)
                        owed_bytes.push_back(pages[it.read_page][it.read_column]);
                    else
                        owed_bytes.push_back('0);
                end
                default: n_nop++;
            endcase
        endfunction

        function void check_byte(logic [PAGE_BYTE_W-1:0] got);
            bit [PAGE_BYTE_W-1:0] want;
            if (owed_bytes.size() == 0) begin
                $error("page_byte: result with no read waiting, expected none, actual %02h",
                       got);
                n_bad++;
            end else begin
                want = owed_bytes.pop_front();
                n_checked++;
                if (got !== want) begin
                    $error("page_byte mismatch: expected %02h, actual %02h", want, got);
                    n_bad++;
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   quiet;
    int   cycle_count;

    t_page_shadow shadow = new();

    rfpf_in_if  in_ch ();
    rfpf_out_if out_ch ();

    rect_fill_page_framebuffer_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // result side: random ready stalls, quiet stretches with ready held high
    initial begin : result_sink
        int hold;
        hold = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n) begin
                if (out_ch.valid && out_ch.ready) begin
                    shadow.check_byte(out_ch.page_byte);
                    hold = quiet ? 0 : $urandom_range(0, MAX_IDLE);
                    if (hold != 0) out_ch.ready <= 1'b0;
                end else if (!out_ch.ready) begin
                    if (hold == 0) out_ch.ready <= 1'b1;
                    else hold--;
                end
            end
        end
    end

    function automatic t_fb_item noise_item();
        t_fb_item it;
        it.op          = t_op'($urandom_range(0, 3));
        it.row_start   = ROW_START_W'($urandom);
        it.col_start   = COL_START_W'($urandom);
        it.rect_height = RECT_HEIGHT_W'($urandom);
        it.rect_width  = RECT_WIDTH_W'($urandom);
        it.read_page   = READ_PAGE_W'($urandom);
        it.read_column = READ_COLUMN_W'($urandom);
        return it;
    endfunction

    function automatic t_fb_item fill_item(int r0, int c0, int h, int w);
        t_fb_item it;
        it             = noise_item();
        it.op          = OP_FILL;
        it.row_start   = ROW_START_W'(r0);
        it.col_start   = COL_START_W'(c0);
        it.rect_height = RECT_HEIGHT_W'(h);
        it.rect_width  = RECT_WIDTH_W'(w);
        return it;
    endfunction

    function automatic t_fb_item read_item(int p, int c);
        t_fb_item it;
        it             = noise_item();
        it.op          = OP_READ;
        it.read_page   = READ_PAGE_W'(p);
        it.read_column = READ_COLUMN_W'(c);
        return it;
    endfunction

    function automatic t_fb_item xfer_item();
        t_fb_item it;
        it    = noise_item();
        it.op = OP_XFER;
        return it;
    endfunction

    // valid stays high across back-to-back items, so it is only lowered for a real gap
    task automatic push_item(input t_fb_item it);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.op          <= it.op;
        in_ch.row_start   <= it.row_start;
        in_ch.col_start   <= it.col_start;
        in_ch.rect_height <= it.rect_height;
        in_ch.rect_width  <= it.rect_width;
        in_ch.read_page   <= it.read_page;
        in_ch.read_column <= it.read_column;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        shadow.note_item(it);
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (shadow.pending() != 0);
    endtask

    // a few fills around one spot, a transfer, then reads over that spot
    task automatic run_scene();
        int r0, c0, nf, nr;
        r0 = $urandom_range(0, ROWS - 1);
        c0 = $urandom_range(0, COLS - 1);
        nf = $urandom_range(1, 3);
        nr = $urandom_range(2, 4);
        repeat (nf)
            push_item(fill_item(r0 + $urandom_range(0, 7), c0 + $urandom_range(0, 7),
                                $urandom_range(0, 4), $urandom_range(0, 10)));
        push_item(xfer_item());
        repeat (nr)
            push_item(read_item((r0 + $urandom_range(0, 8)) / 8, c0 + $urandom_range(0, 10)));
    endtask

    function automatic int items_done();
        return shadow.n_fill + shadow.n_xfer + shadow.n_read;
    endfunction

    initial begin : stimulus
        t_fb_item it;
        int pick;
        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.op          <= OP_NOP;
        in_ch.row_start   <= '0;
        in_ch.col_start   <= '0;
        in_ch.rect_height <= '0;
        in_ch.rect_width  <= '0;
        in_ch.read_page   <= '0;
        in_ch.read_column <= '0;
        quiet = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: cleared state, clipping at both edges, empty rectangles, page split
        push_item(read_item(0, 0));
        push_item(fill_item(0, 0, 1, 1));
        push_item(read_item(0, 0));
        push_item(xfer_item());
        push_item(read_item(0, 0));
        push_item(fill_item(ROWS - 1, COLS - 1, 127, 255));
        push_item(fill_item(10, 10, 0, 20));
        push_item(fill_item(20, 20, 5, 0));
        push_item(fill_item(7, 5, 2, 3));
        push_item(fill_item(60, 120, 64, 128));
        it    = noise_item();
        it.op = OP_NOP;
        push_item(it);
        push_item(xfer_item());
        push_item(read_item(7, 127));
        push_item(read_item(0, 5));
        push_item(read_item(1, 6));
        push_item(read_item(7, 124));
        push_item(read_item(2, 20));
        push_item(read_item(1, 10));
        push_item(read_item(PAGES - 1, 0));
        drain_results();

        while (items_done() < ITEM_TARGET - 12) begin
            if ($urandom_range(0, 39) == 0) quiet = !quiet;
            if (items_done() >= ITEM_TARGET / 2 && items_done() < ITEM_TARGET / 2 + 6)
                drain_results();
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                run_scene();
            end else if (pick < 70) begin
                push_item(read_item($urandom_range(0, PAGES - 1), $urandom_range(0, COLS - 1)));
            end else if (pick < 88) begin
                push_item(fill_item($urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1),
                                    $urandom_range(0, 4), $urandom_range(0, 10)));
            end else if (pick < 93) begin
                // any size, but started near the corner so little of the plane gets lit
                push_item(fill_item($urandom_range(ROWS - 4, ROWS - 1),
                                    $urandom_range(COLS - 8, COLS - 1),
                                    $urandom_range(0, 127), $urandom_range(0, 255)));
            end else if (pick < 96) begin
                push_item(xfer_item());
            end else begin
                it    = noise_item();
                it.op = OP_NOP;
                push_item(it);
            end
        end

        // whole screen last, since it saturates both planes
        quiet = 1'b0;
        push_item(fill_item(0, 0, ROWS, COLS));
        push_item(fill_item(0, 0, 127, 255));
        push_item(xfer_item());
        repeat (8)
            push_item(read_item($urandom_range(0, PAGES - 1), $urandom_range(0, COLS - 1)));
        push_item(read_item(0, 0));
        push_item(read_item(PAGES - 1, COLS - 1));

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d fills, %0d transfers, %0d reads, %0d no-ops",
                 shadow.n_fill, shadow.n_xfer, shadow.n_read, shadow.n_nop);
        $display("%0d page bytes compared, %0d mismatches, %0d reads unanswered",
                 shadow.n_checked, shadow.n_bad, shadow.pending());
        if (shadow.n_bad == 0 && shadow.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
